// ===== src/rrtq_pkg.sv =====
// Shared types and constants for the round-robin task queue.
// No dependencies; every other file imports this package.
package rrtq_pkg;

  // Field widths of the item and result channels
  localparam int unsigned OP_W          = 2;
  localparam int unsigned TASK_ID_W     = 4;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned MAX_TASKS_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd2;

  // Link table read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_TID,
    RD_LINK
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;     // capture the accepted item
    logic                append;   // link task at tail
    logic                rm_head;  // unlink head task, new head from read data
    logic                rm_mid;   // unlink task after prev, bypass via read data
    logic                rotate;   // move head to tail
    logic                emit;     // load output register
    rd_sel_t             rd_sel;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            queued;
    logic            is_head;
    logic            count_lt2;
    logic            link_hit;
    logic            out_busy;
  } sts_t;

endpackage

// ===== src/rrtq_if.sv =====
// Valid/ready channel interfaces for the task queue item and result streams.
// Depends on rrtq_pkg for field widths.
interface rrtq_in_if import rrtq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [TASK_ID_W-1:0] task_id;

  modport source (output valid, operation, task_id, input ready);
  modport sink   (input valid, operation, task_id, output ready);
endinterface

interface rrtq_out_if import rrtq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TASK_ID_W-1:0] head_task;
  logic                 queue_empty;
  logic [LEN_W-1:0]     queue_length;

  modport source (output valid, status, head_task, queue_empty, queue_length, input ready);
  modport sink   (input valid, status, head_task, queue_empty, queue_length, output ready);
endinterface

// ===== src/rrtq_ctrl.sv =====
// Sequencing state machine for the task queue: decode, link walk, result.
// Depends on rrtq_pkg for the command and status structs.
module rrtq_ctrl import rrtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD_RD,
    S_ROT_RD,
    S_WALK,
    S_LINK_RD,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    cmd.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt  = S_EMIT;
        status_nxt = ST_DONE;
        unique case (sts.op)
          OP_APPEND: begin
            if (!sts.in_range) status_nxt = ST_ABSENT;
            else if (sts.queued) status_nxt = ST_DUPLICATE;
            else cmd.append = 1'b1;
          end
          OP_REMOVE: begin
            if (!sts.in_range || !sts.queued) begin
              status_nxt = ST_ABSENT;
            end else if (sts.is_head) begin
              cmd.rd_sel = RD_TID;
              state_nxt  = S_HEAD_RD;
            end else begin
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_WALK;
            end
          end
          OP_ROTATE: begin
            if (!sts.count_lt2) begin
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_ROT_RD;
            end
          end
          default: ;
        endcase
      end
      S_HEAD_RD: begin
        cmd.rm_head = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_ROT_RD: begin
        cmd.rotate = 1'b1;
        state_nxt  = S_EMIT;
      end
      // one link per cycle until the predecessor of the task is found
      S_WALK: begin
        if (sts.link_hit) begin
          cmd.rd_sel = RD_TID;
          state_nxt  = S_LINK_RD;
        end else begin
          cmd.rd_sel = RD_LINK;
        end
      end
      S_LINK_RD: begin
        cmd.rm_mid = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== src/rrtq_dp.sv =====
// Datapath of the task queue: link table, head/tail/count, queued flags,
// output register. Depends on rrtq_pkg; driven by rrtq_ctrl commands.
module rrtq_dp import rrtq_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [TASK_ID_W-1:0] in_task_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [TASK_ID_W-1:0] out_head_task,
  output logic                 out_queue_empty,
  output logic [LEN_W-1:0]     out_queue_length,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  logic [OP_W-1:0]      op_r;
  logic [TASK_ID_W-1:0] tid_r;
  logic [IDX_W-1:0]     tid_idx;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [IDX_W-1:0]     prev_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] flags_r, flags_nxt;

  logic [IDX_W-1:0]     link_mem [MAX_TASKS];
  logic [IDX_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     wr_data;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TASK_ID_W-1:0] out_head_r;
  logic                 out_empty_r;
  logic [LEN_W-1:0]     out_len_r;

  assign tid_idx = IDX_W'(tid_r);

  // Status to the controller
  always_comb begin
    sts.op        = op_r;
    sts.in_range  = (32'(tid_r) < MAX_TASKS);
    sts.queued    = sts.in_range && flags_r[tid_idx];
    sts.is_head   = (head_r == tid_idx);
    sts.count_lt2 = (count_r < CNT_W'(2));
    sts.link_hit  = (rd_data_r == tid_idx);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // Captured item and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      tid_r <= in_task_id;
    end
    if (cmd.rd_sel == RD_HEAD) prev_r <= head_r;
    else if (cmd.rd_sel == RD_LINK) prev_r <= rd_data_r;
  end

  // Link table addressing
  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TID:  rd_addr = tid_idx;
      RD_LINK: rd_addr = rd_data_r;
      default: rd_addr = head_r;
    endcase
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = tid_idx;
    if (cmd.append && (count_r != '0)) begin
      wr_en = 1'b1;
    end else if (cmd.rotate) begin
      wr_en   = 1'b1;
      wr_data = head_r;
    end else if (cmd.rm_mid) begin
      wr_en   = 1'b1;
      wr_addr = prev_r;
      wr_data = rd_data_r;
    end
  end

  // Link table: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (cmd.rd_sel != RD_NONE) rd_data_r <= link_mem[rd_addr];
  end

  // Queue state update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    flags_nxt = flags_r;
    if (cmd.append) begin
      flags_nxt[tid_idx] = 1'b1;
      if (count_r == '0) head_nxt = tid_idx;
      tail_nxt  = tid_idx;
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rm_head) begin
      flags_nxt[tid_idx] = 1'b0;
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        head_nxt = rd_data_r;
      end
    end else if (cmd.rm_mid) begin
      flags_nxt[tid_idx] = 1'b0;
      count_nxt = count_r - CNT_W'(1);
      if (tail_r == tid_idx) tail_nxt = prev_r;
    end else if (cmd.rotate) begin
      head_nxt = rd_data_r;
      tail_nxt = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      flags_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_head_r   <= (count_r == '0) ? '0 : TASK_ID_W'(head_r);
      out_empty_r  <= (count_r == '0);
      out_len_r    <= LEN_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_head_task    = out_head_r;
  assign out_queue_empty  = out_empty_r;
  assign out_queue_length = out_len_r;

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("task count above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0) && (tail_r == '0))
    else $error("head or tail not cleared on empty queue");

  a_flags_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flags_r) == 32'(count_r))
    else $error("queued flags disagree with task count");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result loaded over an untaken result");

endmodule

// ===== src/round_robin_task_queue.sv =====
// Round-robin run queue of task numbers, linked list in a next-link table.
// Append, error, unused-code and short-rotate items pass through the decode and result states only.
// Rotate of two or more tasks and head removal add one state for one link table read.
// Removal from the middle walks the links from the head, one link read per cycle of the walk.
// A stalled result port holds the block in its result state; items are taken one at a time, in idle.
// Synchronous active-low reset empties the queue; the link table is not cleared.
module round_robin_task_queue import rrtq_pkg::*; #(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rrtq_in_if.sink   in_ch,
  rrtq_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rrtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Queue storage and result register
  rrtq_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_ch.operation),
    .in_task_id       (in_ch.task_id),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_head_task    (out_ch.head_task),
    .out_queue_empty  (out_ch.queue_empty),
    .out_queue_length (out_ch.queue_length),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
